### rtl/ahcp_pkg.sv
// shared types, constants and tables for the ascii hex command parser
package ahcp_pkg;

   localparam int POSITION_MAX_DEF = 255;
   localparam int NUM_PREFIX = 12;
   localparam int FIRST_HEX = 6;
   localparam int HDR_LEN = 3;
   localparam int MAX_PFX_LEN = 12;

   // result queue depth, kept a power of two so the pointers wrap on their own
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [3:0] {
      CODE_NONE, CODE_ESTOP, CODE_MANUAL, CODE_START, CODE_STOP, CODE_CALIBRATE,
      CODE_RESET, CODE_THROTTLE, CODE_SETPOINT, CODE_HEARTBEAT, CODE_PID, CODE_BIAS,
      CODE_CONFIG
   } command_type;

   // text is right justified: first character sits in the highest used byte
   localparam logic [MAX_PFX_LEN*8-1:0] PFX_TEXT [NUM_PREFIX] = '{
      "ES", "FC:MANUAL", "FC:START", "FC:STOP", "FC:CALIBRATE", "FC:RESET",
      "ST:", "SP:", "HB:", "TP:", "MB:", "CF:"
   };
   localparam logic [3:0] PFX_LEN [NUM_PREFIX] = '{
      4'd2, 4'd9, 4'd8, 4'd7, 4'd12, 4'd8, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3
   };
   localparam logic [6:0] PAY_LEN [NUM_PREFIX] = '{
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd4, 7'd12, 7'd16, 7'd21, 7'd16, 7'd76
   };

   typedef struct packed {
      logic       result_kind;
      logic [3:0] command_code;
      logic [6:0] payload_index;
      logic [7:0] payload_value;
      logic [6:0] payload_count;
      logic       final_result;
   } result_type;

   // zero, one or two results produced by one accepted request
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] pfx_char(input int idx, input logic [3:0] pos);
      logic [MAX_PFX_LEN*8-1:0] text;
      int sh;
      text = PFX_TEXT[idx];
      sh = (int'(PFX_LEN[idx]) - 1 - int'(pos)) * 8;
      return text[sh +: 8];
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      if (c >= "0" && c <= "9") begin
         n = 4'(c - 8'h30);
      end else if (c >= "A" && c <= "F") begin
         n = 4'(c - 8'h37);
      end else if (c >= "a" && c <= "f") begin
         n = 4'(c - 8'h57);
      end else begin
         n = 4'd0;
      end
      return n;
   endfunction

endpackage

### rtl/ahcp_parser.sv
// per-character prefix matching, hex pair decoding and verdict generation
module ahcp_parser #(
   parameter int POSITION_MAX = ahcp_pkg::POSITION_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              last_byte,
   output ahcp_pkg::push_type push
);
   import ahcp_pkg::*;

   localparam int PosW = $clog2(POSITION_MAX + 1);
   localparam logic [PosW-1:0] PosMax = PosW'(POSITION_MAX);

   logic [PosW-1:0]       pos_ff, pos_in;
   logic [NUM_PREFIX-1:0] mask_ff, mask_in, mask_new;
   logic [3:0]            hn_ff, hn_in;

   logic            hit;
   logic [3:0]      sel;
   logic [PosW-1:0] k, kh, length;
   logic            in_hex, pair_done, found;
   logic [3:0]      vcode;
   logic [6:0]      vcnt;
   logic [3:0]      nib;
   result_type      pay_res, ver_res;

   always_comb begin
      mask_new = mask_ff;
      for (int i = 0; i < NUM_PREFIX; i++) begin
         if (pos_ff < PosW'(PFX_LEN[i]) && in_byte != pfx_char(i, pos_ff[3:0])) begin
            mask_new[i] = 1'b0;
         end
      end

      // first payload header still alive
      hit = 1'b0;
      sel = 4'd0;
      for (int i = FIRST_HEX; i < NUM_PREFIX; i++) begin
         if (!hit && mask_new[i]) begin
            hit = 1'b1;
            sel = 4'(i);
         end
      end

      nib = nibble_of(in_byte);
      k = pos_ff - PosW'(HDR_LEN);
      kh = k >> 1;
      in_hex = (pos_ff >= PosW'(HDR_LEN)) && hit;
      pair_done = in_hex && k[0] && (kh < PosW'(PAY_LEN[sel]));

      length = (pos_ff >= PosMax) ? PosMax : pos_ff + 1'b1;
      found = 1'b0;
      vcode = CODE_NONE;
      vcnt = 7'd0;
      for (int i = 0; i < NUM_PREFIX; i++) begin
         if (!found && mask_new[i] && PosW'(PFX_LEN[i]) <= length &&
             (i < FIRST_HEX ||
              length >= PosW'(HDR_LEN) + (PosW'(PAY_LEN[i]) << 1))) begin
            found = 1'b1;
            vcode = 4'(i + 1);
            vcnt = PAY_LEN[i];
         end
      end

      pay_res.result_kind   = KIND_PAYLOAD;
      pay_res.command_code  = sel + 4'd1;
      pay_res.payload_index = kh[6:0];
      pay_res.payload_value = {hn_ff, nib};
      pay_res.payload_count = 7'd0;
      pay_res.final_result  = !last_byte;

      ver_res.result_kind   = KIND_VERDICT;
      ver_res.command_code  = vcode;
      ver_res.payload_index = 7'd0;
      ver_res.payload_value = 8'd0;
      ver_res.payload_count = vcnt;
      ver_res.final_result  = 1'b1;

      push.first  = pair_done ? pay_res : ver_res;
      push.second = ver_res;
      push.count  = accept ? ({1'b0, pair_done} + {1'b0, last_byte}) : 2'd0;
   end

   always_comb begin
      pos_in  = pos_ff;
      mask_in = mask_ff;
      hn_in   = hn_ff;
      if (accept) begin
         if (last_byte) begin
            pos_in  = '0;
            mask_in = '1;
            hn_in   = 4'd0;
         end else begin
            pos_in  = (pos_ff < PosMax) ? pos_ff + 1'b1 : PosMax;
            mask_in = mask_new;
            hn_in   = (in_hex && !k[0]) ? nib : hn_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mask_ff <= '1;
         hn_ff   <= 4'd0;
      end else begin
         pos_ff  <= pos_in;
         mask_ff <= mask_in;
         hn_ff   <= hn_in;
      end
   end

endmodule

### rtl/ahcp_rsp_fifo.sv
// small result queue taking up to two results per cycle, one out per cycle
module ahcp_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  ahcp_pkg::push_type   push,
   input  logic                 pop,
   output ahcp_pkg::result_type head,
   output logic                 not_empty,
   output logic                 room_for_two
);
   import ahcp_pkg::*;

   result_type           entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   assign head = entries_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room_for_two = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/ascii_hex_command_parser.sv
// ascii hex command parser: one character per cycle, results leave through a 4-entry queue
// a request's results enter the queue at the edge that accepts it
// throughput: one request per cycle unless stalled; one result per cycle leaves the queue
// a last character that also completes a hex pair pushes two results in that cycle
// requests stall while the queue has room for fewer than two results
// reset (synchronous) empties the queue and restarts the message; requests stall during it
module ascii_hex_command_parser #(
   parameter int POSITION_MAX = ahcp_pkg::POSITION_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_result_kind,
   output logic [3:0] rsp_command_code,
   output logic [6:0] rsp_payload_index,
   output logic [7:0] rsp_payload_value,
   output logic [6:0] rsp_payload_count,
   output logic       rsp_final_result
);
   import ahcp_pkg::*;

   push_type   push;
   result_type head;
   logic       room_for_two, accept, pop;

   assign req_stall = reset || !room_for_two;
   assign accept = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;

   ahcp_parser #(
      .POSITION_MAX(POSITION_MAX)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .in_byte(req_in_byte),
      .last_byte(req_last_byte),
      .push(push)
   );

   ahcp_rsp_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .head(head),
      .not_empty(rsp_valid),
      .room_for_two(room_for_two)
   );

   assign rsp_result_kind   = head.result_kind;
   assign rsp_command_code  = head.command_code;
   assign rsp_payload_index = head.payload_index;
   assign rsp_payload_value = head.payload_value;
   assign rsp_payload_count = head.payload_count;
   assign rsp_final_result  = head.final_result;

endmodule

### rtl/ahcp_checker.sv
// port-level checks for the ascii hex command parser, bound to the top level
module ahcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_result_kind,
   input logic [3:0] rsp_command_code,
   input logic [6:0] rsp_payload_index,
   input logic [7:0] rsp_payload_value,
   input logic [6:0] rsp_payload_count,
   input logic       rsp_final_result
);
   import ahcp_pkg::*;

   // queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_command_code) && $stable(rsp_payload_index) &&
      $stable(rsp_payload_value) && $stable(rsp_payload_count) &&
      $stable(rsp_final_result))
      else $error("stalled result changed");

   // a verdict always closes the results of its request
   a_verdict_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_VERDICT |-> rsp_final_result)
      else $error("verdict not marked final");

   // decoded bytes only belong to payload headers and carry no count
   a_payload_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_PAYLOAD |->
      rsp_payload_count == 7'd0 && rsp_command_code >= CODE_THROTTLE &&
      rsp_command_code <= CODE_CONFIG)
      else $error("bad payload result");

   // a nonzero count only comes with a payload command
   a_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_VERDICT && rsp_payload_count != 7'd0 |->
      rsp_command_code >= CODE_THROTTLE)
      else $error("payload count on a command without payload");

endmodule

bind ascii_hex_command_parser ahcp_checker u_ahcp_checker (.*);

### tb/ascii_hex_command_parser_check.sv
// checker for the ascii hex command parser: predicts each result from the accepted requests
module ascii_hex_command_parser_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_result_kind,
   input  logic [3:0] rsp_command_code,
   input  logic [6:0] rsp_payload_index,
   input  logic [7:0] rsp_payload_value,
   input  logic [6:0] rsp_payload_count,
   input  logic       rsp_final_result,
   output int         mismatch_count,
   output int         outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import ahcp_pkg::*;

   localparam int POSITION_LIMIT = POSITION_MAX_DEF;
   localparam int PAYLOAD_BYTES [NUM_PREFIX] = '{0, 0, 0, 0, 0, 0, 4, 12, 16, 21, 16, 76};
   localparam command_type PREFIX_CODE [NUM_PREFIX] = '{
      CODE_ESTOP, CODE_MANUAL, CODE_START, CODE_STOP, CODE_CALIBRATE, CODE_RESET,
      CODE_THROTTLE, CODE_SETPOINT, CODE_HEARTBEAT, CODE_PID, CODE_BIAS, CODE_CONFIG
   };

   int unsigned           char_count;
   logic [NUM_PREFIX-1:0] still_matching;
   logic [3:0]            pending_high;
   result_type            expected_results [$];

   function automatic string prefix_text(input int idx);
      unique case (idx)
         0: return "ES";
         1: return "FC:MANUAL";
         2: return "FC:START";
         3: return "FC:STOP";
         4: return "FC:CALIBRATE";
         5: return "FC:RESET";
         6: return "ST:";
         7: return "SP:";
         8: return "HB:";
         9: return "TP:";
         10: return "MB:";
         default: return "CF:";
      endcase
   endfunction

   // anything that is not a hex digit decodes to zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return c[3:0];
      end
      if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         return c[3:0] + 4'd9;
      end
      return 4'd0;
   endfunction

   function automatic void start_message();
      char_count = 0;
      still_matching = '1;
      pending_high = 4'd0;
   endfunction

   function automatic void predict_char(input logic [7:0] c, input logic lst);
      int unsigned pos;
      int unsigned k;
      int unsigned length;
      int          size_before;
      bit          found;
      string       txt;
      result_type  r;
      size_before = expected_results.size();
      pos = char_count;
      for (int i = 0; i < NUM_PREFIX; i++) begin
         txt = prefix_text(i);
         if (pos < txt.len() && c != txt[pos]) begin
            still_matching[i] = 1'b0;
         end
      end
      // first surviving payload header owns the hex pairs
      if (pos >= HDR_LEN) begin
         k = pos - HDR_LEN;
         found = 1'b0;
         for (int i = FIRST_HEX; i < NUM_PREFIX; i++) begin
            if (!found && still_matching[i]) begin
               found = 1'b1;
               if (k % 2 == 0) begin
                  pending_high = hex_value(c);
               end else if (k / 2 < PAYLOAD_BYTES[i]) begin
                  r = '0;
                  r.result_kind = KIND_PAYLOAD;
                  r.command_code = PREFIX_CODE[i];
                  r.payload_index = 7'(k / 2);
                  r.payload_value = {pending_high, hex_value(c)};
                  expected_results.push_back(r);
               end
            end
         end
      end
      char_count = (pos < POSITION_LIMIT) ? pos + 1 : POSITION_LIMIT;
      if (lst) begin
         length = (pos >= POSITION_LIMIT) ? POSITION_LIMIT : pos + 1;
         r = '0;
         r.result_kind = KIND_VERDICT;
         r.command_code = CODE_NONE;
         found = 1'b0;
         for (int i = 0; i < NUM_PREFIX; i++) begin
            txt = prefix_text(i);
            if (!found && still_matching[i] && txt.len() <= length &&
                (i < FIRST_HEX || length >= HDR_LEN + 2 * PAYLOAD_BYTES[i])) begin
               found = 1'b1;
               r.command_code = PREFIX_CODE[i];
               r.payload_count = 7'(PAYLOAD_BYTES[i]);
            end
         end
         expected_results.push_back(r);
         start_message();
      end
      if (expected_results.size() > size_before) begin
         r = expected_results.pop_back();
         r.final_result = 1'b1;
         expected_results.push_back(r);
      end
   endfunction

   function automatic void note_mismatch(input string what, input result_type want,
                                         input result_type got);
      if (mismatch_count < 10) begin
         $display("%0t %s: expected kind=%0d code=%0d idx=%0d val=%02h cnt=%0d fin=%0d",
                  $realtime, what, want.result_kind, want.command_code, want.payload_index,
                  want.payload_value, want.payload_count, want.final_result);
         $display("%0t %s: actual   kind=%0d code=%0d idx=%0d val=%02h cnt=%0d fin=%0d",
                  $realtime, what, got.result_kind, got.command_code, got.payload_index,
                  got.payload_value, got.payload_count, got.final_result);
      end
      mismatch_count = mismatch_count + 1;
   endfunction

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         expected_results.delete();
         start_message();
         mismatch_count = 0;
      end else begin
         // results leaving at this edge come from requests taken at earlier edges
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_result_kind, rsp_command_code, rsp_payload_index,
                   rsp_payload_value, rsp_payload_count, rsp_final_result};
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected result", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.result_kind !== want.result_kind ||
                   got.command_code !== want.command_code ||
                   got.payload_index !== want.payload_index ||
                   got.payload_value !== want.payload_value ||
                   got.payload_count !== want.payload_count ||
                   got.final_result !== want.final_result) begin
                  note_mismatch("result mismatch", want, got);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_char(req_in_byte, req_last_byte);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

### tb/ascii_hex_command_parser_test.sv
// testbench top for the ascii hex command parser: clock, reset, request and result traffic
module ascii_hex_command_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_result_kind;
   logic [3:0] rsp_command_code;
   logic [6:0] rsp_payload_index;
   logic [7:0] rsp_payload_value;
   logic [6:0] rsp_payload_count;
   logic       rsp_final_result;
   int         mismatch_count;
   int         outstanding;

   logic [7:0] msg [$];
   int         chars_sent;
   bit         send_burst;

   ascii_hex_command_parser u_dut (.*);

   ascii_hex_command_parser_check u_check (.*);

   always #10 clock = ~clock;

   function automatic string header_text(input int sel);
      unique case (sel)
         0: return "ES";
         1: return "FC:MANUAL";
         2: return "FC:START";
         3: return "FC:STOP";
         4: return "FC:CALIBRATE";
         5: return "FC:RESET";
         6: return "ST:";
         7: return "SP:";
         8: return "HB:";
         9: return "TP:";
         10: return "MB:";
         default: return "CF:";
      endcase
   endfunction

   function automatic void push_text(input string s);
      for (int j = 0; j < s.len(); j++) begin
         msg.push_back(s[j]);
      end
   endfunction

   // mostly real hex digits of both cases, now and then any byte
   function automatic logic [7:0] random_hex();
      string digits;
      digits = "0123456789abcdefABCDEF";
      if ($urandom_range(99) < 88) begin
         return digits[$urandom_range(21)];
      end
      return 8'($urandom_range(255));
   endfunction

   function automatic void push_payload(input int sel);
      if (sel >= ahcp_pkg::FIRST_HEX) begin
         repeat (2 * ahcp_pkg::PAY_LEN[sel]) msg.push_back(random_hex());
      end
   endfunction

   function automatic void push_junk(input int count);
      repeat (count) msg.push_back(8'($urandom_range(255)));
   endfunction

   // the long config header is kept rare
   function automatic int pick_payload_header();
      if ($urandom_range(99) < 5) begin
         return 11;
      end
      return $urandom_range(10, ahcp_pkg::FIRST_HEX);
   endfunction

   function automatic int sender_gap();
      int roll;
      if (send_burst) begin
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 65) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(3, 1);
      end else if (roll < 98) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(60, 20);
   endfunction

   task automatic send_char(input logic [7:0] c, input logic lst);
      int gap;
      req_valid <= 1'b1;
      req_in_byte <= c;
      req_last_byte <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_msg();
      send_burst = ($urandom_range(4) == 0);
      for (int j = 0; j < msg.size(); j++) begin
         send_char(msg[j], j == msg.size() - 1);
      end
      msg.delete();
   endtask

   task automatic random_message();
      int roll;
      int sel;
      int keep;
      int pos;
      roll = $urandom_range(99);
      if (roll < 55) begin
         sel = pick_payload_header();
         push_text(header_text(sel));
         push_payload(sel);
         if ($urandom_range(3) == 0) push_junk($urandom_range(6, 1));
      end else if (roll < 72) begin
         sel = $urandom_range(ahcp_pkg::FIRST_HEX - 1);
         push_text(header_text(sel));
         if ($urandom_range(3) == 0) push_junk($urandom_range(6, 1));
      end else if (roll < 84) begin
         // message cut short anywhere in the header or the payload
         sel = $urandom_range(11);
         push_text(header_text(sel));
         push_payload(sel);
         keep = $urandom_range(msg.size() - 1, 1);
         while (msg.size() > keep) void'(msg.pop_back());
      end else if (roll < 93) begin
         // one flipped bit in the header
         sel = $urandom_range(11);
         push_text(header_text(sel));
         pos = $urandom_range(msg.size() - 1);
         msg[pos] = msg[pos] ^ (8'h01 << $urandom_range(7));
         push_payload(sel);
      end else begin
         push_junk($urandom_range(12, 1));
      end
      send_msg();
   endtask

   initial begin
      int sel;
      int waited;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_in_byte <= 8'h00;
      req_last_byte <= 1'b0;
      chars_sent = 0;
      send_burst = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // bad digit, mixed case, extra character past the payload
      push_text("ST:9aFg0fA1x");
      send_msg();
      // too short, its payload byte still goes out
      push_text("SP:12");
      send_msg();
      msg.push_back(8'h00);
      send_msg();
      msg.push_back(8'hFF);
      send_msg();
      push_text("ES");
      send_msg();

      // long message so the position count saturates
      sel = $urandom_range(11);
      push_text(header_text(sel));
      push_payload(sel);
      push_junk(290 - msg.size());
      send_msg();

      while (chars_sent < 1100) random_message();
      req_valid <= 1'b0;

      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result side back pressure, with one long hold so the requests back up
   initial begin
      int run;
      int roll;
      int cycles_seen;
      bit held_off;
      rsp_stall <= 1'b0;
      cycles_seen = 0;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && cycles_seen > 800) begin
            held_off = 1'b1;
            run = 400;
         end else begin
            roll = $urandom_range(99);
            if (roll < 50) begin
               run = 0;
            end else if (roll < 85) begin
               run = $urandom_range(3, 1);
            end else if (roll < 97) begin
               run = $urandom_range(20, 4);
            end else begin
               run = $urandom_range(80, 30);
            end
         end
         if (run > 0) begin
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
            cycles_seen += run;
         end
         run = ($urandom_range(99) < 10) ? $urandom_range(300, 50) : $urandom_range(8, 1);
         rsp_stall <= 1'b0;
         repeat (run) @(posedge clock);
         cycles_seen += run;
      end
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
